/* src/mpv_pkg.sv */
`default_nettype none
package mpv_pkg;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ROUNDS = 64;
  localparam int unsigned ROUND_W = 6;

  // Compression pass selectors
  localparam logic [1:0] PASS_MSG = 2'd0;
  localparam logic [1:0] PASS_PAD = 2'd1;
  localparam logic [1:0] PASS_OUTER = 2'd2;

  typedef logic [HASH_W-1:0] hword_t;
  typedef logic [31:0] sword_t;
  typedef logic [255:0] state_t;
  typedef logic [511:0] block_t;

  // Handshake between sequencer and compression core
  typedef struct packed {
    logic start;
    logic use_init;
  } core_ctl_t;

  localparam state_t SHA_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic sword_t round_k(input logic [ROUND_W-1:0] i);
    sword_t k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* src/mpv_if.sv */
`default_nettype none
interface mpv_in_if;
  logic valid;
  logic ready;
  logic [63:0] hash_word0;
  logic [63:0] hash_word1;
  logic [63:0] hash_word2;
  logic [63:0] hash_word3;
  logic is_leaf;
  logic sibling_on_right;
  logic is_last;
  modport source (output valid, hash_word0, hash_word1, hash_word2, hash_word3,
                  is_leaf, sibling_on_right, is_last, input ready);
  modport sink (input valid, hash_word0, hash_word1, hash_word2, hash_word3,
                is_leaf, sibling_on_right, is_last, output ready);
endinterface

interface mpv_out_if;
  logic valid;
  logic ready;
  logic proof_valid;
  modport source (output valid, proof_valid, input ready);
  modport sink (input valid, proof_valid, output ready);
endinterface

interface mpv_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/mpv_core.sv */
`default_nettype none
// One SHA-256 compression, one round per cycle, message schedule in a
// 16-word shift window.
module mpv_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mpv_pkg::core_ctl_t ctl,
  input  wire mpv_pkg::state_t chain_in,
  input  wire mpv_pkg::block_t blk,
  output mpv_pkg::state_t chain_out,
  output logic done
);

  logic busy;
  logic [mpv_pkg::ROUND_W-1:0] rnd;
  mpv_pkg::sword_t w [16];
  mpv_pkg::sword_t va, vb, vc, vd, ve, vf, vg, vh;
  mpv_pkg::state_t base;

  mpv_pkg::sword_t s0, s1, wn, e1, ch, t1, a0, mj;

  // schedule and round datapath
  always_comb begin
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    e1 = {ve[5:0], ve[31:6]} ^ {ve[10:0], ve[31:11]} ^ {ve[24:0], ve[31:25]};
    ch = (ve & vf) ^ (~ve & vg);
    t1 = vh + e1 + ch + mpv_pkg::round_k(rnd) + w[0];
    a0 = {va[1:0], va[31:2]} ^ {va[12:0], va[31:13]} ^ {va[21:0], va[31:22]};
    mj = (va & vb) ^ (va & vc) ^ (vb & vc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == mpv_pkg::ROUND_W'(mpv_pkg::ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload: working variables, schedule window, chaining value
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      base <= ctl.use_init ? mpv_pkg::SHA_INIT : chain_in;
      {va, vb, vc, vd, ve, vf, vg, vh} <= ctl.use_init ? mpv_pkg::SHA_INIT : chain_in;
      for (int i = 0; i < 16; i++) w[i] <= blk[511-32*i -: 32];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + a0 + mj;
    end
  end

  // feed-forward add
  always_comb begin
    chain_out = {base[255:224] + va, base[223:192] + vb, base[191:160] + vc,
                 base[159:128] + vd, base[127:96] + ve, base[95:64] + vf,
                 base[63:32] + vg, base[31:0] + vh};
  end

endmodule
`default_nettype wire

/* src/merkle_proof_verifier_sha256d.sv */
`default_nettype none
// Channel | Dir | Words carried
// in      | in  | hash_word0..3, is_leaf, sibling_on_right, is_last
// out     | out | proof_valid (only for words with is_last)
// cfg     | in  | index 0..3 -> root_word0..3
// A leaf word goes straight to the compare step; a sibling word takes three
// 64-round compressions on the one shared round unit, plus start/done steps.
// rst (synchronous) clears the running hash and root registers.
// in.ready is low while a word is in work or its result waits on out.
// cfg is always ready; writes are expected only while idle.
module merkle_proof_verifier_sha256d (
  input wire logic clk,
  input wire logic rst,
  mpv_in_if.sink   in,
  mpv_out_if.source out,
  mpv_cfg_if.sink  cfg
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [1:0] pass;
  mpv_pkg::hword_t root [mpv_pkg::NUM_WORDS];
  logic [255:0] run_hash;
  logic [511:0] msg;
  logic last;
  mpv_pkg::state_t chain, chain_out;
  mpv_pkg::core_ctl_t ctl;
  mpv_pkg::block_t blk;
  logic done;

  assign in.ready  = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out.valid = (state == ST_OUT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mpv_pkg::NUM_WORDS; i++) root[i] <= '0;
    end else if (cfg.valid) begin
      root[cfg.index] <= cfg.data;
    end
  end

  // block selection per pass
  always_comb begin
    unique case (pass)
      mpv_pkg::PASS_MSG: blk = msg;
      mpv_pkg::PASS_PAD: blk = {32'h80000000, 448'd0, 32'd512};
      default:           blk = {chain, 32'h80000000, 192'd0, 32'd256};
    endcase
  end

  mpv_core u_core (
    .clk(clk), .rst(rst), .ctl(ctl), .chain_in(chain),
    .blk(blk), .chain_out(chain_out), .done(done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      run_hash <= '0;
      ctl      <= '0;
      pass     <= mpv_pkg::PASS_MSG;
    end else begin
      ctl <= '0;
      unique case (state)
        ST_IDLE: if (in.valid) begin
          last <= in.is_last;
          if (in.is_leaf) begin
            run_hash <= {in.hash_word0, in.hash_word1, in.hash_word2, in.hash_word3};
            state <= ST_CMP;
          end else begin
            msg <= in.sibling_on_right ?
              {run_hash, in.hash_word0, in.hash_word1, in.hash_word2, in.hash_word3} :
              {in.hash_word0, in.hash_word1, in.hash_word2, in.hash_word3, run_hash};
            pass <= mpv_pkg::PASS_MSG;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          ctl.start    <= 1'b1;
          ctl.use_init <= (pass != mpv_pkg::PASS_PAD);
          state <= ST_WAIT;
        end
        ST_WAIT: if (done) begin
          chain <= chain_out;
          if (pass == mpv_pkg::PASS_OUTER) begin
            run_hash <= chain_out;
            state <= ST_CMP;
          end else begin
            pass  <= pass + 1'b1;
            state <= ST_RUN;
          end
        end
        ST_CMP: begin
          out.proof_valid <= (run_hash == {root[0], root[1], root[2], root[3]});
          state <= last ? ST_OUT : ST_IDLE;
        end
        ST_OUT: if (out.ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // no new word while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("accept while result pending");
  // core only finishes while the sequencer waits for it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_WAIT) else $error("stray core done");
  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.proof_valid))
    else $error("result dropped");

endmodule
`default_nettype wire
